### rtl/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int unsigned RADIX_BITS    = 6;
  localparam int unsigned CHAR_BITS     = 8;
  localparam int unsigned DIV_STEP_BITS = 8;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_BITS-1:0] DIGIT_MAX = 6'd9;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] ASCII_LC_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'h2d;

  typedef logic [RADIX_BITS-1:0] radix_t;
  typedef logic [CHAR_BITS-1:0]  char_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_RD,
    ST_OUT
  } itoa_state_t;

  function automatic char_t digit_char(input radix_t d);
    char_t ch;
    if (d > DIGIT_MAX) begin
      ch = ASCII_LC_A + CHAR_BITS'(d) - CHAR_BITS'(RADIX_DEC);
    end else begin
      ch = ASCII_ZERO + CHAR_BITS'(d);
    end
    return ch;
  endfunction

endpackage

### rtl/itoa_if.sv
`timescale 1ns / 1ps

interface itoa_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [5:0]            base;

  modport source (output valid, output value, output base, input ready);
  modport sink   (input valid, input value, input base, output ready);
endinterface

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;
  logic       was_nonzero;

  modport source (output valid, output character, output last_char, output was_nonzero,
                  input ready);
  modport sink   (input valid, input character, input last_char, input was_nonzero,
                  output ready);
endinterface

### rtl/integer_to_ascii_radix_unit.sv
`timescale 1ns / 1ps

// Integer to ASCII text in radix 2 to 36.
// in_if carries a VALUE_BITS-bit two's complement value and a 6-bit radix;
// a radix below 2 or above 36 is clamped into that range. out_if carries one
// character per transaction, most significant digit first, with last_char on
// the final one and was_nonzero clear only for a zero value. A '-' leads only
// negative values in radix 10; other radices read the bits as unsigned.
// When the text is longer than MAX_DIGITS, only its last MAX_DIGITS
// characters are sent.
// in_if.ready is high only while the unit is idle: one value is converted at
// a time. A shared 8-bit-per-cycle long divider produces each digit in one
// pass over the ceil(VALUE_BITS/8) bytes of the magnitude, least significant
// digit first, into a digit store. Each character is then read through the
// registered digit store read port before it is sent; a sign, if any, is
// sent first. A zero value skips the divider. A stalled receiver holds the
// current character and the unit waits. Reset (synchronous, rst_n low)
// returns the unit to idle and drops any conversion in progress.
module integer_to_ascii_radix_unit
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  itoa_in_if.sink     in_if,
  itoa_out_if.source  out_if
);

  localparam int NCH     = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PADW    = NCH * DIV_STEP_BITS;
  localparam int CHW     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int CNT_MAX = (VALUE_BITS > MAX_DIGITS) ? VALUE_BITS : MAX_DIGITS;
  localparam int CNTW    = $clog2(CNT_MAX + 1);
  localparam int IDXW    = $clog2(MAX_DIGITS);

  localparam logic [CNTW-1:0] MAXD      = CNTW'(MAX_DIGITS);
  localparam logic [CHW-1:0]  LAST_CHNK = CHW'(NCH - 1);

  itoa_state_t state_r, state_nxt;

  logic [PADW-1:0]       mag_r, mag_nxt;
  radix_t                rem_r, rem_nxt;
  radix_t                radix_r, radix_nxt;
  logic [CHW-1:0]        chunk_r, chunk_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic [IDXW-1:0]       pos_r, pos_nxt;
  logic                  sign_r, sign_nxt;
  logic                  nz_r, nz_nxt;

  radix_t                store [MAX_DIGITS];
  radix_t                rd_data_r;
  logic                  wr_en;
  logic [IDXW-1:0]       wr_addr;
  radix_t                wr_data;

  logic [VALUE_BITS-1:0] in_val;
  radix_t                in_radix;
  logic                  in_neg;
  logic [DIV_STEP_BITS-1:0] chunk_bits;
  logic [DIV_STEP_BITS-1:0] q_bits;
  radix_t                div_rem;
  logic [PADW-1:0]       div_mag;
  logic [CNTW-1:0]       cnt_inc;
  logic [CNTW-1:0]       start_pos;

  assign in_val = in_if.value;

  always_comb begin
    if (in_if.base < RADIX_MIN) begin
      in_radix = RADIX_MIN;
    end else if (in_if.base > RADIX_MAX) begin
      in_radix = RADIX_MAX;
    end else begin
      in_radix = in_if.base;
    end
  end

  assign in_neg = (in_radix == RADIX_DEC) && in_val[VALUE_BITS-1];

  // Restoring division of one byte of the dividend by the radix.
  always_comb begin
    logic [RADIX_BITS:0] t;
    radix_t              r;
    r = rem_r;
    chunk_bits = mag_r[PADW-1 -: DIV_STEP_BITS];
    for (int i = DIV_STEP_BITS - 1; i >= 0; i--) begin
      t = {r, chunk_bits[i]};
      if (t >= {1'b0, radix_r}) begin
        q_bits[i] = 1'b1;
        r         = RADIX_BITS'(t - {1'b0, radix_r});
      end else begin
        q_bits[i] = 1'b0;
        r         = t[RADIX_BITS-1:0];
      end
    end
    div_rem = r;
    div_mag = (mag_r << DIV_STEP_BITS) | PADW'(q_bits);
  end

  assign cnt_inc   = cnt_r + CNTW'(1);
  assign start_pos = (cnt_inc < MAXD) ? cnt_r : (MAXD - CNTW'(1));

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    radix_nxt = radix_r;
    chunk_nxt = chunk_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    sign_nxt  = sign_r;
    nz_nxt    = nz_r;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[IDXW-1:0];
    wr_data   = div_rem;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          radix_nxt = in_radix;
          rem_nxt   = '0;
          chunk_nxt = '0;
          if (in_val == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = '0;
            cnt_nxt   = CNTW'(1);
            sign_nxt  = 1'b0;
            nz_nxt    = 1'b0;
            pos_nxt   = '0;
            state_nxt = ST_RD;
          end else begin
            mag_nxt   = in_neg ? PADW'(VALUE_BITS'(-in_val)) : PADW'(in_val);
            cnt_nxt   = '0;
            sign_nxt  = in_neg;
            nz_nxt    = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        mag_nxt   = div_mag;
        rem_nxt   = div_rem;
        chunk_nxt = chunk_r + CHW'(1);
        if (chunk_r == LAST_CHNK) begin
          wr_en     = (cnt_r < MAXD);
          cnt_nxt   = cnt_inc;
          rem_nxt   = '0;
          chunk_nxt = '0;
          if (div_mag == '0) begin
            pos_nxt   = start_pos[IDXW-1:0];
            state_nxt = (sign_r && (cnt_inc < MAXD)) ? ST_SIGN : ST_RD;
          end
        end
      end
      ST_SIGN: begin
        if (out_if.ready) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_if.ready) begin
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt   = pos_r - IDXW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sign_r  <= 1'b0;
      chunk_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sign_r  <= sign_nxt;
      chunk_r <= chunk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
    pos_r   <= pos_nxt;
    nz_r    <= nz_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data_r <= store[pos_r];
  end

  assign in_if.ready        = (state_r == ST_IDLE);
  assign out_if.valid       = (state_r == ST_OUT) || (state_r == ST_SIGN);
  assign out_if.character   = (state_r == ST_SIGN) ? ASCII_MINUS : digit_char(rd_data_r);
  assign out_if.last_char   = (state_r == ST_OUT) && (pos_r == '0);
  assign out_if.was_nonzero = nz_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input taken while a character is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("unit ready right after accepting a value");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && out_if.last_char) |=> in_if.ready)
    else $error("unit not idle after the final character");

  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ((radix_r >= RADIX_MIN) && (radix_r <= RADIX_MAX)))
    else $error("divider running with radix out of range");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb
  import itoa_pkg::*;
();

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT      = 5000;
  localparam int unsigned DRAIN_CYCLES     = 300;

  typedef struct packed {
    char_t character;
    logic  last_char;
    logic  was_nonzero;
  } text_char_t;

  logic clk;
  logic rst_n;

  itoa_in_if #(.VALUE_BITS(VALUE_BITS)) in_if ();
  itoa_out_if                            out_if ();

  integer_to_ascii_radix_unit #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  text_char_t  pending_chars[$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;
  logic        hold_request;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void predict_text(input logic [VALUE_BITS-1:0] value,
                                       input radix_t base);
    radix_t                radix;
    logic [VALUE_BITS-1:0] magnitude;
    logic [VALUE_BITS-1:0] digit;
    char_t                 text[$];
    text_char_t            entry;

    radix = base;
    if (radix < RADIX_MIN) begin
      radix = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix = RADIX_MAX;
    end
    if (value == '0) begin
      entry = '{character: ASCII_ZERO, last_char: 1'b1, was_nonzero: 1'b0};
      pending_chars.push_back(entry);
      return;
    end
    magnitude = value;
    if (radix == RADIX_DEC && value[VALUE_BITS-1]) begin
      magnitude = -value;
    end
    while (magnitude != '0) begin
      digit = magnitude % radix;
      if (digit > DIGIT_MAX) begin
        text.push_front(ASCII_LC_A + char_t'(digit) - char_t'(RADIX_DEC));
      end else begin
        text.push_front(ASCII_ZERO + char_t'(digit));
      end
      magnitude = magnitude / radix;
    end
    if (radix == RADIX_DEC && value[VALUE_BITS-1]) begin
      text.push_front(ASCII_MINUS);
    end
    while (text.size() > MAX_DIGITS) begin
      void'(text.pop_front());
    end
    foreach (text[i]) begin
      entry = '{character: text[i], last_char: (i == text.size() - 1), was_nonzero: 1'b1};
      pending_chars.push_back(entry);
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4:          v = $urandom_range(100);
      5:          v = -$urandom_range(100);
      6:          v = 32'h8000_0000 + $urandom_range(3);
      7:          v = 32'h7fff_ffff - $urandom_range(3);
      8:          v = 32'd1 << $urandom_range(31);
      default:    v = $urandom >> $urandom_range(31);
    endcase
    return v;
  endfunction

  function automatic radix_t random_base();
    radix_t b;
    if ($urandom_range(99) < 85) begin
      b = radix_t'($urandom_range(36, 2));
    end else begin
      b = radix_t'($urandom_range(63));
    end
    return b;
  endfunction

  task automatic send_number(input logic [VALUE_BITS-1:0] value, input radix_t base);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    in_if.base  <= base;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    predict_text(value, base);
  endtask

  task automatic test_directed();
    send_number(32'd0, 6'd10);
    send_number(32'd0, 6'd2);
    send_number(32'd0, 6'd0);
    send_number(32'h8000_0000, 6'd10);
    send_number(32'h8000_0000, 6'd2);
    send_number(32'h8000_0000, 6'd16);
    send_number(32'h7fff_ffff, 6'd10);
    send_number(32'h7fff_ffff, 6'd36);
    send_number(32'h7fff_ffff, 6'd2);
    send_number(32'hffff_ffff, 6'd10);
    send_number(32'hffff_ffff, 6'd2);
    send_number(32'hffff_ffff, 6'd16);
    send_number(32'hffff_ffff, 6'd36);
    send_number(32'hffff_ffff, 6'd8);
    send_number(32'd35, 6'd36);
    send_number(32'd10, 6'd16);
    send_number(32'd1, 6'd2);
    send_number(32'd123, 6'd0);
    send_number(32'd123, 6'd1);
    send_number(32'd123, 6'd37);
    send_number(32'd123, 6'd63);
    send_number(-32'd42, 6'd10);
    send_number(32'd255, 6'd16);
    send_number(32'd9, 6'd10);
  endtask

  task automatic test_random_numbers(input int unsigned count);
    repeat (count) begin
      send_number(random_value(), random_base());
    end
  endtask

  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (10) begin
      send_number(random_value(), random_base());
    end
  endtask

  initial begin
    int unsigned held;
    bit          hold_done;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_if.ready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_done = 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: character expected none actual %h", $time, out_if.character);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_if.character !== want.character) begin
          $display("%0t: character expected %h actual %h", $time, want.character,
                   out_if.character);
          error_count++;
        end
        if (out_if.last_char !== want.last_char) begin
          $display("%0t: last_char expected %b actual %b", $time, want.last_char,
                   out_if.last_char);
          error_count++;
        end
        if (out_if.was_nonzero !== want.was_nonzero) begin
          $display("%0t: was_nonzero expected %b actual %b", $time, want.was_nonzero,
                   out_if.was_nonzero);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    hold_request  = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 78;
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    in_if.base  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_numbers(130);

    send_idle_pct = 78;
    recv_idle_pct = 32;
    test_random_numbers(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_numbers(116);
    in_if.valid <= 1'b0;

    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
